>>> src/circle_rect_collide_resolve_defines.svh
// Assertion macros shared by the collision blocks.
`ifndef CIRCLE_RECT_COLLIDE_RESOLVE_DEFINES_SVH
`define CIRCLE_RECT_COLLIDE_RESOLVE_DEFINES_SVH

// The condition implies the property in the same cycle.
`define CRC_ASSERT_IMPLY(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// The condition implies the property in the next cycle.
`define CRC_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> src/crc_pkg.sv
`default_nettype none

package crc_pkg;

   localparam int CW     = 24;
   localparam int SZW    = CW - 2;
   localparam int DW     = CW + 3;
   localparam int RW     = CW;
   localparam int QW     = CW;
   localparam int RMW    = 2 * RW + 2;
   localparam int QDEPTH = 4;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   localparam logic signed [CW-1:0] MOVE_HI = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MOVE_LO = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW:0] QLIM_POS = {2'b00, {(CW-1){1'b1}}};
   localparam logic [CW:0] QLIM_NEG = {2'b01, {(CW-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_CC,
      KIND_CR,
      KIND_RR
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic                   swap;
      logic                   pc;
      logic                   pr;
      logic signed [DW-1:0]   ddx;
      logic signed [DW-1:0]   ddy;
      logic [RW-1:0]          r2;
      logic [SZW-1:0]         rad;
      logic [CW-2:0]          sumx;
      logic [CW-2:0]          sumy;
   } item_type;

endpackage

`default_nettype wire

>>> src/circle_rect_collide_resolve.sv
// An accepted word passes the input queue, the square-root pipeline and the restoring
// divider, one bit per stage each, before its result word appears.
// Throughput: one word per clock cycle while pop keeps up; a four-word input queue
// takes new words while the back pipeline is held by a result that waits.
// Reset is synchronous and active high; it empties the queue and the pipeline.
`default_nettype none

module circle_rect_collide_resolve (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic                          req_shape_a,
   input  wire logic                          req_shape_b,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_a_x,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_a_y,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_b_x,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_b_y,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_a_x,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_a_y,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_b_x,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_b_y,
   input  wire logic                          req_push_a,
   input  wire logic                          req_push_b,
   output logic                               empty,
   input  wire logic                          pop,
   output logic                               rsp_hit,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_a_x,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_a_y,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_b_x,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_b_y,
   output logic                               rsp_stop_a_vx,
   output logic                               rsp_stop_a_vy,
   output logic                               rsp_stop_b_vx,
   output logic                               rsp_stop_b_vy
);

   crc_pkg::item_type wr_item, rd_item;
   logic              wr_en, rd_en, q_empty;

   assign wr_en = push && !full;

   crc_front u_front (
      .req_shape_a  (req_shape_a),
      .req_shape_b  (req_shape_b),
      .req_pos_a_x  (req_pos_a_x),
      .req_pos_a_y  (req_pos_a_y),
      .req_pos_b_x  (req_pos_b_x),
      .req_pos_b_y  (req_pos_b_y),
      .req_size_a_x (req_size_a_x),
      .req_size_a_y (req_size_a_y),
      .req_size_b_x (req_size_b_x),
      .req_size_b_y (req_size_b_y),
      .req_push_a   (req_push_a),
      .req_push_b   (req_push_b),
      .item         (wr_item)
   );

   crc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_item (wr_item),
      .full    (full),
      .rd_en   (rd_en),
      .rd_item (rd_item),
      .empty   (q_empty)
   );

   crc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .rd_item       (rd_item),
      .q_empty       (q_empty),
      .rd_en         (rd_en),
      .pop           (pop),
      .empty         (empty),
      .rsp_hit       (rsp_hit),
      .rsp_move_a_x  (rsp_move_a_x),
      .rsp_move_a_y  (rsp_move_a_y),
      .rsp_move_b_x  (rsp_move_b_x),
      .rsp_move_b_y  (rsp_move_b_y),
      .rsp_stop_a_vx (rsp_stop_a_vx),
      .rsp_stop_a_vy (rsp_stop_a_vy),
      .rsp_stop_b_vx (rsp_stop_b_vx),
      .rsp_stop_b_vy (rsp_stop_b_vy)
   );

endmodule

`default_nettype wire

>>> src/crc_front.sv
`default_nettype none

module crc_front (
   input  wire logic                       req_shape_a,
   input  wire logic                       req_shape_b,
   input  wire logic signed [crc_pkg::CW-1:0]  req_pos_a_x,
   input  wire logic signed [crc_pkg::CW-1:0]  req_pos_a_y,
   input  wire logic signed [crc_pkg::CW-1:0]  req_pos_b_x,
   input  wire logic signed [crc_pkg::CW-1:0]  req_pos_b_y,
   input  wire logic [crc_pkg::SZW-1:0]    req_size_a_x,
   input  wire logic [crc_pkg::SZW-1:0]    req_size_a_y,
   input  wire logic [crc_pkg::SZW-1:0]    req_size_b_x,
   input  wire logic [crc_pkg::SZW-1:0]    req_size_b_y,
   input  wire logic                       req_push_a,
   input  wire logic                       req_push_b,
   output crc_pkg::item_type               item
);

   localparam int CW  = crc_pkg::CW;
   localparam int SZW = crc_pkg::SZW;
   localparam int DW  = crc_pkg::DW;
   localparam int RW  = crc_pkg::RW;

   logic signed [DW-1:0] ax, ay, bx, by;

   assign ax = DW'(signed'({req_pos_a_x, 1'b0}));
   assign ay = DW'(signed'({req_pos_a_y, 1'b0}));
   assign bx = DW'(signed'({req_pos_b_x, 1'b0}));
   assign by = DW'(signed'({req_pos_b_y, 1'b0}));

   always_comb begin
      logic signed [DW-1:0] cx, cy, rx, ry, wx, hy, lox, hix, loy, hiy, qx, qy;
      logic [SZW-1:0]       rad;
      cx  = req_shape_a ? bx : ax;
      cy  = req_shape_a ? by : ay;
      rx  = req_shape_a ? ax : bx;
      ry  = req_shape_a ? ay : by;
      wx  = signed'(DW'(req_shape_a ? req_size_a_x : req_size_b_x));
      hy  = signed'(DW'(req_shape_a ? req_size_a_y : req_size_b_y));
      rad = req_shape_a ? req_size_b_x : req_size_a_x;
      lox = rx - wx;
      hix = rx + wx;
      loy = ry - hy;
      hiy = ry + hy;
      qx  = (cx < lox) ? lox : ((cx > hix) ? hix : cx);
      qy  = (cy < loy) ? loy : ((cy > hiy) ? hiy : cy);

      item      = '0;
      item.rad  = rad;
      item.sumx = (CW-1)'(req_size_a_x) + (CW-1)'(req_size_b_x);
      item.sumy = (CW-1)'(req_size_a_y) + (CW-1)'(req_size_b_y);
      if (req_shape_a == req_shape_b) begin
         item.kind = req_shape_a ? crc_pkg::KIND_RR : crc_pkg::KIND_CC;
         item.swap = 1'b0;
         item.pc   = req_push_a;
         item.pr   = req_push_b;
         item.ddx  = ax - bx;
         item.ddy  = ay - by;
         item.r2   = {item.sumx, 1'b0};
      end else begin
         item.kind = crc_pkg::KIND_CR;
         item.swap = req_shape_a;
         item.pc   = req_shape_a ? req_push_b : req_push_a;
         item.pr   = req_shape_a ? req_push_a : req_push_b;
         item.ddx  = cx - qx;
         item.ddy  = cy - qy;
         item.r2   = RW'({rad, 1'b0});
      end
   end

endmodule

`default_nettype wire

>>> src/crc_queue.sv
`default_nettype none

`include "circle_rect_collide_resolve_defines.svh"

module crc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  crc_pkg::item_type      wr_item,
   output logic                   full,
   input  wire logic              rd_en,
   output crc_pkg::item_type      rd_item,
   output logic                   empty
);

   localparam int QDEPTH = crc_pkg::QDEPTH;
   localparam int QPW    = crc_pkg::QPW;
   localparam int QCW    = crc_pkg::QCW;

   crc_pkg::item_type mem_ff [QDEPTH];
   logic [QPW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]    cnt_ff, cnt_in;

   assign full    = (cnt_ff == QCW'(QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCW'(wr_en) - QCW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   `CRC_ASSERT_IMPLY(a_q_no_overflow, wr_en, !full, "queue written while full")
   `CRC_ASSERT_IMPLY(a_q_no_underflow, rd_en, !empty, "queue read while empty")
   `CRC_ASSERT_NEXT(a_q_count, (wr_en && !rd_en), (cnt_ff == $past(cnt_ff) + QCW'(1)), "queue count did not grow")

endmodule

`default_nettype wire

>>> src/crc_back.sv
`default_nettype none

`include "circle_rect_collide_resolve_defines.svh"

module crc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  crc_pkg::item_type                  rd_item,
   input  wire logic                          q_empty,
   output logic                               rd_en,
   input  wire logic                          pop,
   output logic                               empty,
   output logic                               rsp_hit,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_a_x,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_a_y,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_b_x,
   output logic signed [crc_pkg::CW-1:0]      rsp_move_b_y,
   output logic                               rsp_stop_a_vx,
   output logic                               rsp_stop_a_vy,
   output logic                               rsp_stop_b_vx,
   output logic                               rsp_stop_b_vy
);

   localparam int CW  = crc_pkg::CW;
   localparam int SZW = crc_pkg::SZW;
   localparam int DW  = crc_pkg::DW;
   localparam int RW  = crc_pkg::RW;
   localparam int QW  = crc_pkg::QW;
   localparam int RMW = crc_pkg::RMW;

   typedef struct packed {
      crc_pkg::kind_type kind;
      logic              swap;
      logic              pc;
      logic              pr;
      logic              near;
      logic              sgnx;
      logic              sgny;
      logic [RW-1:0]     magx;
      logic [RW-1:0]     magy;
      logic [RW-1:0]     r2;
      logic [SZW-1:0]    rad;
      logic              rrhit;
      logic              rrx;
      logic              rrneg;
      logic [CW-2:0]     rrmag;
      logic              hit;
      logic              lt;
      logic              zero;
      logic [RW+1:0]     dd;
   } ctl_type;

   typedef struct packed {
      logic [2*RW-1:0] x;
      logic [2*RW-1:0] r;
   } sq_type;

   typedef struct packed {
      logic [RMW-1:0] rem;
      logic [QW-1:0]  q;
   } dv_type;

   function automatic sq_type sq_step(sq_type s, int unsigned k);
      logic [2*RW-1:0] b;
      sq_type          o;
      b = (2*RW)'(1) << (2 * (RW - 1 - k));
      o = s;
      if (s.x >= s.r + b) begin
         o.x = s.x - (s.r + b);
         o.r = (s.r >> 1) + b;
      end else begin
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   function automatic dv_type dv_step(dv_type s, logic [RW+1:0] d, int unsigned i);
      logic [RMW-1:0] trial;
      dv_type         o;
      trial = RMW'(d) << i;
      o     = s;
      if (s.rem >= trial) begin
         o.rem = s.rem - trial;
         o.q   = {s.q[QW-2:0], 1'b1};
      end else begin
         o.q   = {s.q[QW-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic signed [CW-1:0] smove(logic neg, logic [CW:0] q);
      logic signed [CW-1:0] m;
      if (!neg) begin
         m = (q > crc_pkg::QLIM_POS) ? crc_pkg::MOVE_HI : signed'(q[CW-1:0]);
      end else begin
         m = (q > crc_pkg::QLIM_NEG) ? crc_pkg::MOVE_LO : -signed'(q[CW-1:0]);
      end
      return m;
   endfunction

   function automatic logic signed [CW-1:0] negsat(logic signed [CW-1:0] m);
      return (m == crc_pkg::MOVE_LO) ? crc_pkg::MOVE_HI : -m;
   endfunction

   logic adv;

   ctl_type               s1_ctl_ff, s1_ctl_in;
   logic                  v1_ff;
   ctl_type               s2_ctl_ff;
   logic [2*RW-1:0]       s2_sqx_ff, s2_sqy_ff, s2_rr_ff;
   logic                  v2_ff;
   ctl_type               s3_ctl_ff;
   logic [2*RW:0]         s3_d2_ff, s3_d2_in;
   logic [2*RW-1:0]       s3_rr_ff;
   logic                  v3_ff;
   ctl_type               s4_ctl_ff, s4_ctl_in;
   logic [2*RW-1:0]       s4_x_ff;
   logic                  v4_ff;
   sq_type                sq_ff [RW];
   sq_type                sq_in [RW];
   ctl_type               sq_ctl_ff [RW];
   logic [RW-1:0]         sq_v_ff;
   ctl_type               s5_ctl_ff, s5_ctl_in;
   logic [RW-1:0]         s5_ov_ff, s5_ov_in;
   logic                  v5_ff;
   ctl_type               s6_ctl_ff;
   logic [2*RW-1:0]       s6_nx_ff, s6_ny_ff;
   logic                  v6_ff;
   dv_type                dvx_ff [QW];
   dv_type                dvx_in [QW];
   dv_type                dvy_ff [QW];
   dv_type                dvy_in [QW];
   ctl_type               dv_ctl_ff [QW];
   logic [QW-1:0]         dv_v_ff;
   logic                  out_vld_ff;
   logic                  hit_ff, hit_in;
   logic signed [CW-1:0]  max_ff, max_in, may_ff, may_in, mbx_ff, mbx_in, mby_ff, mby_in;
   logic [3:0]            stop_ff, stop_in;

   assign adv   = !out_vld_ff || pop;
   assign rd_en = adv && !q_empty;
   assign empty = !out_vld_ff;

   assign rsp_hit       = hit_ff;
   assign rsp_move_a_x  = max_ff;
   assign rsp_move_a_y  = may_ff;
   assign rsp_move_b_x  = mbx_ff;
   assign rsp_move_b_y  = mby_ff;
   assign rsp_stop_a_vx = stop_ff[0];
   assign rsp_stop_a_vy = stop_ff[1];
   assign rsp_stop_b_vx = stop_ff[2];
   assign rsp_stop_b_vy = stop_ff[3];

   always_comb begin
      logic [DW-1:0]      mfx, mfy;
      logic signed [DW:0] ox, oy;
      logic [CW-2:0]      ov;
      logic [CW-1:0]      ovp;
      logic               both;
      mfx  = rd_item.ddx[DW-1] ? DW'(-rd_item.ddx) : DW'(rd_item.ddx);
      mfy  = rd_item.ddy[DW-1] ? DW'(-rd_item.ddy) : DW'(rd_item.ddy);
      ox   = signed'((DW+1)'(rd_item.sumx)) - signed'((DW+1)'(mfx));
      oy   = signed'((DW+1)'(rd_item.sumy)) - signed'((DW+1)'(mfy));
      both = rd_item.pc && rd_item.pr;
      s1_ctl_in       = '0;
      s1_ctl_in.kind  = rd_item.kind;
      s1_ctl_in.swap  = rd_item.swap;
      s1_ctl_in.pc    = rd_item.pc;
      s1_ctl_in.pr    = rd_item.pr;
      s1_ctl_in.near  = (mfx <= DW'(rd_item.r2)) && (mfy <= DW'(rd_item.r2));
      s1_ctl_in.sgnx  = rd_item.ddx[DW-1];
      s1_ctl_in.sgny  = rd_item.ddy[DW-1];
      s1_ctl_in.magx  = mfx[RW-1:0];
      s1_ctl_in.magy  = mfy[RW-1:0];
      s1_ctl_in.r2    = rd_item.r2;
      s1_ctl_in.rad   = rd_item.rad;
      s1_ctl_in.rrhit = (ox > 0) && (oy > 0);
      s1_ctl_in.rrx   = (ox < oy);
      s1_ctl_in.rrneg = s1_ctl_in.rrx ? rd_item.ddx[DW-1] : rd_item.ddy[DW-1];
      ov  = s1_ctl_in.rrx ? ox[CW-2:0] : oy[CW-2:0];
      ovp = CW'(ov) + (both ? CW'(2) : CW'(1));
      s1_ctl_in.rrmag = both ? (CW-1)'(ovp[CW-1:2]) : ovp[CW-1:1];
   end

   always_comb begin
      s3_d2_in = (2*RW+1)'(s2_sqx_ff) + (2*RW+1)'(s2_sqy_ff);
   end

   always_comb begin
      s4_ctl_in      = s3_ctl_ff;
      s4_ctl_in.hit  = s3_ctl_ff.near && (s3_d2_ff <= (2*RW+1)'(s3_rr_ff));
      s4_ctl_in.lt   = (s3_d2_ff < (2*RW+1)'(s3_rr_ff));
      s4_ctl_in.zero = (s3_d2_ff == '0);
   end

   always_comb begin
      sq_type s0;
      s0.x     = s4_x_ff;
      s0.r     = '0;
      sq_in[0] = sq_step(s0, 0);
      for (int k = 1; k < RW; k++) begin
         sq_in[k] = sq_step(sq_ff[k-1], k);
      end
   end

   always_comb begin
      logic [RW-1:0] root;
      root      = sq_ff[RW-1].r[RW-1:0];
      s5_ctl_in = sq_ctl_ff[RW-1];
      s5_ov_in  = sq_ctl_ff[RW-1].r2 - root;
      s5_ctl_in.dd = (sq_ctl_ff[RW-1].pc && sq_ctl_ff[RW-1].pr) ?
                     {root, 2'b00} : {1'b0, root, 1'b0};
   end

   always_comb begin
      dv_type x0, y0;
      x0.rem    = RMW'(s6_nx_ff);
      x0.q      = '0;
      y0.rem    = RMW'(s6_ny_ff);
      y0.q      = '0;
      dvx_in[0] = dv_step(x0, s6_ctl_ff.dd, QW - 1);
      dvy_in[0] = dv_step(y0, s6_ctl_ff.dd, QW - 1);
      for (int k = 1; k < QW; k++) begin
         dvx_in[k] = dv_step(dvx_ff[k-1], dv_ctl_ff[k-1].dd, QW - 1 - k);
         dvy_in[k] = dv_step(dvy_ff[k-1], dv_ctl_ff[k-1].dd, QW - 1 - k);
      end
   end

   always_comb begin
      ctl_type              c;
      dv_type               dx, dy;
      logic [CW:0]          qrx, qry;
      logic                 upx, upy, push_n, zc, any;
      logic signed [CW-1:0] mx, my, zmv, m, cx, cy, rx, ry;
      logic [SZW:0]         zm;
      c   = dv_ctl_ff[QW-1];
      dx  = dvx_ff[QW-1];
      dy  = dvy_ff[QW-1];
      any = c.pc || c.pr;
      upx = (RMW'({dx.rem, 1'b0}) >= RMW'(c.dd));
      upy = (RMW'({dy.rem, 1'b0}) >= RMW'(c.dd));
      qrx = (CW+1)'(dx.q) + (CW+1)'(upx);
      qry = (CW+1)'(dy.q) + (CW+1)'(upy);
      mx  = smove(c.sgnx, qrx);
      my  = smove(c.sgny, qry);
      zm  = (c.pc && c.pr) ? ((SZW+1)'(c.rad) + (SZW+1)'(1)) >> 1 : (SZW+1)'(c.rad);
      zmv = signed'(CW'(zm));
      m   = c.rrneg ? -signed'(CW'(c.rrmag)) : signed'(CW'(c.rrmag));
      push_n  = c.hit && c.lt && !c.zero && any;
      zc      = (c.kind == crc_pkg::KIND_CR) && c.hit && c.lt && c.zero && any;
      cx      = '0;
      cy      = '0;
      rx      = '0;
      ry      = '0;
      hit_in  = 1'b0;
      stop_in = '0;
      case (c.kind) inside
         crc_pkg::KIND_CC, crc_pkg::KIND_CR: begin
            hit_in = c.hit;
            if (push_n) begin
               cx = c.pc ? mx : '0;
               cy = c.pc ? my : '0;
               rx = c.pr ? negsat(mx) : '0;
               ry = c.pr ? negsat(my) : '0;
            end
            if (zc) begin
               cy = c.pc ? -zmv : '0;
               ry = c.pr ? zmv : '0;
            end
         end
         crc_pkg::KIND_RR: begin
            hit_in = c.rrhit;
            if (c.rrhit && any) begin
               if (c.rrx) begin
                  cx         = c.pc ? m : '0;
                  rx         = c.pr ? negsat(m) : '0;
                  stop_in[0] = c.pc;
                  stop_in[2] = c.pr;
               end else begin
                  cy         = c.pc ? m : '0;
                  ry         = c.pr ? negsat(m) : '0;
                  stop_in[1] = c.pc;
                  stop_in[3] = c.pr;
               end
            end
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
      max_in = c.swap ? rx : cx;
      may_in = c.swap ? ry : cy;
      mbx_in = c.swap ? cx : rx;
      mby_in = c.swap ? cy : ry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         sq_v_ff    <= '0;
         v5_ff      <= 1'b0;
         v6_ff      <= 1'b0;
         dv_v_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         v1_ff      <= !q_empty;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         sq_v_ff    <= {sq_v_ff[RW-2:0], v4_ff};
         v5_ff      <= sq_v_ff[RW-1];
         v6_ff      <= v5_ff;
         dv_v_ff    <= {dv_v_ff[QW-2:0], v6_ff};
         out_vld_ff <= dv_v_ff[QW-1];
      end
      if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s2_sqx_ff <= (2*RW)'(s1_ctl_ff.magx) * (2*RW)'(s1_ctl_ff.magx);
         s2_sqy_ff <= (2*RW)'(s1_ctl_ff.magy) * (2*RW)'(s1_ctl_ff.magy);
         s2_rr_ff  <= (2*RW)'(s1_ctl_ff.r2) * (2*RW)'(s1_ctl_ff.r2);
         s3_ctl_ff <= s2_ctl_ff;
         s3_d2_ff  <= s3_d2_in;
         s3_rr_ff  <= s2_rr_ff;
         s4_ctl_ff <= s4_ctl_in;
         s4_x_ff   <= s3_d2_ff[2*RW-1:0];
         sq_ctl_ff[0] <= s4_ctl_ff;
         for (int k = 0; k < RW; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         for (int k = 1; k < RW; k++) begin
            sq_ctl_ff[k] <= sq_ctl_ff[k-1];
         end
         s5_ctl_ff <= s5_ctl_in;
         s5_ov_ff  <= s5_ov_in;
         s6_ctl_ff <= s5_ctl_ff;
         s6_nx_ff  <= (2*RW)'(s5_ctl_ff.magx) * (2*RW)'(s5_ov_ff);
         s6_ny_ff  <= (2*RW)'(s5_ctl_ff.magy) * (2*RW)'(s5_ov_ff);
         dv_ctl_ff[0] <= s6_ctl_ff;
         for (int k = 0; k < QW; k++) begin
            dvx_ff[k] <= dvx_in[k];
            dvy_ff[k] <= dvy_in[k];
         end
         for (int k = 1; k < QW; k++) begin
            dv_ctl_ff[k] <= dv_ctl_ff[k-1];
         end
         hit_ff  <= hit_in;
         max_ff  <= max_in;
         may_ff  <= may_in;
         mbx_ff  <= mbx_in;
         mby_ff  <= mby_in;
         stop_ff <= stop_in;
      end
   end

   `CRC_ASSERT_IMPLY(a_miss_no_move, (out_vld_ff && !hit_ff), ((max_ff == '0) && (may_ff == '0) && (mbx_ff == '0) && (mby_ff == '0) && (stop_ff == '0)), "move reported without a hit")
   `CRC_ASSERT_IMPLY(a_one_axis, out_vld_ff, ($onehot0(stop_ff[1:0]) && $onehot0(stop_ff[3:2])), "velocity stop on both axes")

endmodule

`default_nettype wire

>>> verif/collide_checker.sv
`timescale 1ns / 1ps

module collide_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic                          full,
   input  wire logic                          req_shape_a,
   input  wire logic                          req_shape_b,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_a_x,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_a_y,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_b_x,
   input  wire logic signed [crc_pkg::CW-1:0] req_pos_b_y,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_a_x,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_a_y,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_b_x,
   input  wire logic [crc_pkg::SZW-1:0]       req_size_b_y,
   input  wire logic                          req_push_a,
   input  wire logic                          req_push_b,
   input  wire logic                          empty,
   input  wire logic                          pop,
   input  wire logic                          rsp_hit,
   input  wire logic signed [crc_pkg::CW-1:0] rsp_move_a_x,
   input  wire logic signed [crc_pkg::CW-1:0] rsp_move_a_y,
   input  wire logic signed [crc_pkg::CW-1:0] rsp_move_b_x,
   input  wire logic signed [crc_pkg::CW-1:0] rsp_move_b_y,
   input  wire logic                          rsp_stop_a_vx,
   input  wire logic                          rsp_stop_a_vy,
   input  wire logic                          rsp_stop_b_vx,
   input  wire logic                          rsp_stop_b_vy,
   output int                                 failures,
   output int                                 pending
);
   import crc_pkg::*;

   typedef struct {
      bit               hit;
      longint           mv[4];
      bit               stop[4];
   } outcome_type;

   outcome_type awaited[$];

   localparam longint SAT_HI = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (CW - 1));

   function automatic longint clip(longint v);
      return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
   endfunction

   function automatic longint absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint floor_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint round_div(longint unsigned n, longint unsigned d);
      longint unsigned q, rm;
      q = n / d;
      rm = n % d;
      if (rm >= d - rm) q++;
      return longint'(q);
   endfunction

   function automatic longint push_along(longint diff, longint ov, longint root,
                                         longint den);
      longint m;
      m = clip(round_div(absval(diff) * ov, root * den));
      return diff < 0 ? clip(-m) : m;
   endfunction

   // Circle at (cx,cy) with doubled radius r2 against a rectangle with half sizes w,h.
   function automatic bit circle_box(longint cx, longint cy, longint r2, longint rx,
                                     longint ry, longint w, longint h, bit cp, bit rp,
                                     longint rad, ref longint cm[2], ref longint rm[2]);
      longint qx, qy, ddx, ddy, root, ov, den, mx, my, m;
      longint unsigned d2, rr;
      qx = cx < rx - w ? rx - w : (cx > rx + w ? rx + w : cx);
      qy = cy < ry - h ? ry - h : (cy > ry + h ? ry + h : cy);
      ddx = cx - qx;
      ddy = cy - qy;
      if (absval(ddx) > r2 || absval(ddy) > r2) return 0;
      d2 = ddx * ddx + ddy * ddy;
      rr = r2 * r2;
      if (d2 > rr) return 0;
      if (d2 < rr && (cp || rp)) begin
         root = floor_sqrt(d2);
         if (root == 0) begin
            m = -round_div(rad, (cp && rp) ? 2 : 1);
            cm[1] = cp ? clip(m) : 0;
            rm[1] = rp ? clip(-m) : 0;
         end else begin
            ov = r2 - root;
            den = (cp && rp) ? 4 : 2;
            mx = push_along(ddx, ov, root, den);
            my = push_along(ddy, ov, root, den);
            if (cp) begin
               cm[0] = mx;
               cm[1] = my;
            end
            if (rp) begin
               rm[0] = clip(-mx);
               rm[1] = clip(-my);
            end
         end
      end
      return 1;
   endfunction

   function automatic outcome_type resolve_pair();
      outcome_type o;
      longint ax, ay, bx, by, awx, awy, bwx, bwy, r2, ddx, ddy, root, ov, den;
      longint ox, oy, m, ma[2], mb[2];
      longint unsigned d2;
      bit pa, pb;
      int k;
      ax = 2 * longint'(req_pos_a_x);
      ay = 2 * longint'(req_pos_a_y);
      bx = 2 * longint'(req_pos_b_x);
      by = 2 * longint'(req_pos_b_y);
      awx = longint'(req_size_a_x);
      awy = longint'(req_size_a_y);
      bwx = longint'(req_size_b_x);
      bwy = longint'(req_size_b_y);
      pa = req_push_a;
      pb = req_push_b;
      ma = '{0, 0};
      mb = '{0, 0};
      o.hit = 0;
      o.stop = '{0, 0, 0, 0};
      den = (pa && pb) ? 4 : 2;
      if (!req_shape_a && !req_shape_b) begin
         r2 = 2 * (awx + bwx);
         ddx = ax - bx;
         ddy = ay - by;
         if (absval(ddx) <= r2 && absval(ddy) <= r2) begin
            d2 = ddx * ddx + ddy * ddy;
            if (d2 <= longint'(r2 * r2)) begin
               root = floor_sqrt(d2);
               o.hit = 1;
               if ((pa || pb) && root != 0 && root < r2) begin
                  ov = r2 - root;
                  ma[0] = push_along(ddx, ov, root, den);
                  ma[1] = push_along(ddy, ov, root, den);
                  mb[0] = pb ? clip(-ma[0]) : 0;
                  mb[1] = pb ? clip(-ma[1]) : 0;
                  if (!pa) ma = '{0, 0};
               end
            end
         end
      end else if (req_shape_a && req_shape_b) begin
         ddx = ax - bx;
         ddy = ay - by;
         ox = awx + bwx - absval(ddx);
         oy = awy + bwy - absval(ddy);
         if (ox > 0 && oy > 0) begin
            o.hit = 1;
            if (pa || pb) begin
               k = ox < oy ? 0 : 1;
               m = clip(round_div(k == 0 ? ox : oy, den));
               if ((k == 0 ? ddx : ddy) < 0) m = clip(-m);
               if (pa) begin
                  ma[k] = m;
                  o.stop[k] = 1;
               end
               if (pb) begin
                  mb[k] = clip(-m);
                  o.stop[2 + k] = 1;
               end
            end
         end
      end else if (!req_shape_a) begin
         o.hit = circle_box(ax, ay, 2 * awx, bx, by, bwx, bwy, pa, pb, awx, ma, mb);
      end else begin
         o.hit = circle_box(bx, by, 2 * bwx, ax, ay, awx, awy, pb, pa, bwx, mb, ma);
      end
      o.mv = '{ma[0], ma[1], mb[0], mb[1]};
      return o;
   endfunction

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (push && !full) awaited.push_back(resolve_pair());
         if (pop && !empty) begin
            if (awaited.size() == 0) begin
               $error("result word with no pending pair");
               failures++;
            end else begin
               want = awaited.pop_front();
               compare_field("hit", longint'(want.hit), longint'(rsp_hit));
               compare_field("move_a_x", want.mv[0], longint'(rsp_move_a_x));
               compare_field("move_a_y", want.mv[1], longint'(rsp_move_a_y));
               compare_field("move_b_x", want.mv[2], longint'(rsp_move_b_x));
               compare_field("move_b_y", want.mv[3], longint'(rsp_move_b_y));
               compare_field("stop_a_vx", longint'(want.stop[0]), longint'(rsp_stop_a_vx));
               compare_field("stop_a_vy", longint'(want.stop[1]), longint'(rsp_stop_a_vy));
               compare_field("stop_b_vx", longint'(want.stop[2]), longint'(rsp_stop_b_vx));
               compare_field("stop_b_vy", longint'(want.stop[3]), longint'(rsp_stop_b_vy));
            end
         end
      end
      pending <= awaited.size();
   end

   initial failures = 0;
   initial pending = 0;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import crc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic full, empty;
   logic req_shape_a = 0, req_shape_b = 0, req_push_a = 0, req_push_b = 0;
   logic signed [CW-1:0] req_pos_a_x = 0, req_pos_a_y = 0, req_pos_b_x = 0, req_pos_b_y = 0;
   logic [SZW-1:0] req_size_a_x = 0, req_size_a_y = 0, req_size_b_x = 0, req_size_b_y = 0;
   logic rsp_hit, rsp_stop_a_vx, rsp_stop_a_vy, rsp_stop_b_vx, rsp_stop_b_vy;
   logic signed [CW-1:0] rsp_move_a_x, rsp_move_a_y, rsp_move_b_x, rsp_move_b_y;
   int failures, pending;
   int cycles = 0;
   bit sending_done = 0;
   bit hold_long = 0;

   typedef struct {
      bit                   sa, sb, pa, pb;
      logic signed [CW-1:0] ax, ay, bx, by;
      logic [SZW-1:0]       wax, way, wbx, wby;
   } pair_type;

   circle_rect_collide_resolve dut (.*);
   collide_checker watcher (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] base, int span);
      return base + CW'($urandom_range(0, 2 * span)) - CW'(span);
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int mode, span;
      p.sa = 1'($urandom);
      p.sb = 1'($urandom);
      p.pa = 1'($urandom);
      p.pb = 1'($urandom);
      mode = $urandom_range(0, 9);
      p.ax = CW'($urandom);
      p.ay = CW'($urandom);
      if (mode < 7) begin
         span = 1 << $urandom_range(2, 12);
         p.wax = SZW'($urandom_range(0, span));
         p.way = SZW'($urandom_range(0, span));
         p.wbx = SZW'($urandom_range(0, span));
         p.wby = SZW'($urandom_range(0, span));
         p.bx = near(p.ax, 2 * span);
         p.by = near(p.ay, 2 * span);
      end else if (mode < 9) begin
         p.wax = SZW'($urandom);
         p.way = SZW'($urandom);
         p.wbx = SZW'($urandom);
         p.wby = SZW'($urandom);
         p.bx = near(p.ax, 1 << 22);
         p.by = near(p.ay, 1 << 22);
      end else begin
         p.wax = SZW'($urandom);
         p.way = SZW'($urandom);
         p.wbx = SZW'($urandom);
         p.wby = SZW'($urandom);
         p.bx = CW'($urandom);
         p.by = CW'($urandom);
      end
      return p;
   endfunction

   function automatic pair_type make_pair(bit sa, bit sb, longint ax, longint ay,
                                          longint bx, longint by, longint wax,
                                          longint way, longint wbx, longint wby,
                                          bit pa, bit pb);
      pair_type p;
      p = '{sa, sb, pa, pb, CW'(ax), CW'(ay), CW'(bx), CW'(by),
            SZW'(wax), SZW'(way), SZW'(wbx), SZW'(wby)};
      return p;
   endfunction

   task automatic send_pair(pair_type p);
      int g;
      g = gap_length();
      if (g != 0) push <= 0;
      repeat (g) @(posedge clock);
      push <= 1;
      req_shape_a <= p.sa;
      req_shape_b <= p.sb;
      req_push_a <= p.pa;
      req_push_b <= p.pb;
      req_pos_a_x <= p.ax;
      req_pos_a_y <= p.ay;
      req_pos_b_x <= p.bx;
      req_pos_b_y <= p.by;
      req_size_a_x <= p.wax;
      req_size_a_y <= p.way;
      req_size_b_x <= p.wbx;
      req_size_b_y <= p.wby;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   localparam longint PMAX = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint PMIN = -(longint'(1) <<< (CW - 1));
   localparam longint SMAX = (longint'(1) <<< SZW) - 1;

   initial begin
      pair_type directed[$];
      directed.push_back(make_pair(0, 0, 0, 0, 100, 0, 60, 0, 60, 0, 1, 1));
      directed.push_back(make_pair(0, 0, 0, 0, 120, 0, 60, 0, 60, 0, 1, 1));
      directed.push_back(make_pair(0, 0, 5, 5, 5, 5, 10, 0, 10, 0, 1, 0));
      directed.push_back(make_pair(0, 0, 0, 0, 30, 40, 40, 0, 20, 0, 0, 0));
      directed.push_back(make_pair(0, 0, PMAX, PMAX, PMIN, PMIN, SMAX, SMAX, SMAX, SMAX, 1, 1));
      directed.push_back(make_pair(0, 0, PMIN, 0, PMAX, 0, SMAX, 0, SMAX, 0, 0, 1));
      directed.push_back(make_pair(0, 1, 10, 10, 0, 0, 20, 0, 40, 40, 1, 1));
      directed.push_back(make_pair(1, 0, 0, 0, 10, 10, 40, 40, 20, 0, 1, 0));
      directed.push_back(make_pair(0, 1, 50, 0, 0, 0, 30, 0, 40, 40, 1, 1));
      directed.push_back(make_pair(0, 1, 60, 5, 0, 0, 30, 0, 60, 60, 0, 1));
      directed.push_back(make_pair(1, 0, 0, 0, 20, 70, 20, 40, 60, 0, 1, 1));
      directed.push_back(make_pair(1, 1, 0, 0, 10, 20, 40, 60, 40, 60, 1, 1));
      directed.push_back(make_pair(1, 1, 0, 0, 0, 0, 40, 40, 40, 40, 1, 0));
      directed.push_back(make_pair(1, 1, 0, 0, 40, 0, 20, 20, 20, 20, 1, 1));
      directed.push_back(make_pair(1, 1, 0, 0, -30, 5, 40, 40, 40, 40, 0, 1));
      directed.push_back(make_pair(1, 1, 0, 0, 10, 10, 40, 40, 40, 40, 1, 1));
      directed.push_back(make_pair(1, 1, PMIN, PMIN, PMAX, PMAX, SMAX, SMAX, SMAX, SMAX, 1, 1));
      directed.push_back(make_pair(1, 0, PMAX, PMIN, PMIN, PMAX, SMAX, SMAX, SMAX, 0, 1, 1));
      directed.push_back(make_pair(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
      directed.push_back(make_pair(1, 1, 0, 0, 3, 0, 0, 0, 0, 0, 1, 1));
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_pair(directed[i]);
      for (int n = 0; n < 1800; n++) send_pair(random_pair());
      push <= 0;
      sending_done = 1;
   end

   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_long = 1;
      repeat (200) @(posedge clock);
      hold_long = 0;
   end

   always @(posedge clock) begin
      if (reset || hold_long) begin
         pop <= 0;
      end else if ($urandom_range(0, 99) < 25) begin
         pop <= 0;
      end else if ($urandom_range(0, 199) == 0) begin
         pop <= 0;
      end else begin
         pop <= 1;
      end
   end

   initial begin
      wait (sending_done);
      @(posedge clock);
      while (pending != 0 || !empty) @(posedge clock);
      repeat (80) @(posedge clock);
      if (failures == 0 && empty) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
